>>> rtl/note_set_change_to_midi_events_core_macros.svh
// assertion macros for the note set change core
`ifndef NOTE_SET_CHANGE_TO_MIDI_EVENTS_CORE_MACROS_SVH
`define NOTE_SET_CHANGE_TO_MIDI_EVENTS_CORE_MACROS_SVH

`ifndef SYNTHESIS

// clocked assertion with an explicit clock and active-low reset
`define NSC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// clocked assertion on the core clock and reset
`define NSC_ASSERT(lbl, prop, msg) \
  `NSC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define NSC_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define NSC_ASSERT(lbl, prop, msg)

`endif

`endif

>>> rtl/nsc_pkg.sv
package nsc_pkg;

  // field widths
  localparam int NOTE_W = 7;
  localparam int VEL_W  = 7;

  // velocity codes
  localparam logic [VEL_W-1:0] VEL_ON  = 7'h7F;
  localparam logic [VEL_W-1:0] VEL_OFF = 7'h00;

  // defaults for the top level parameters
  localparam int NOTE_COUNT_DEF = 128;
  localparam int VOICES_DEF     = 8;

  // events per frame are capped at this count
  localparam int MAX_EVENTS = 16;

  // width of one scan segment of the change vector
  localparam int SEG_W = 16;

  // status of the frame queue toward both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> rtl/nsc_front.sv
module nsc_front #(
  parameter int NOTE_COUNT = nsc_pkg::NOTE_COUNT_DEF,
  parameter int VOICES     = nsc_pkg::VOICES_DEF,
  parameter int PAD_W      = 128
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [nsc_pkg::NOTE_W-1:0] note_slot_i,
  input  logic                      frame_end_i,
  input  nsc_pkg::q_status_t        q_status_i,
  output logic                      q_push_o,
  output logic [PAD_W-1:0]          q_diff_o,
  output logic [PAD_W-1:0]          q_cur_o
);

  localparam int NI_W = $clog2(NOTE_COUNT);
  localparam int CW   = $clog2(VOICES + 1);

  logic [NOTE_COUNT-1:0] cur_q, cur_d, prev_q;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [NI_W-1:0]       idx;
  logic                  in_range;
  logic                  take;
  logic                  accept;

  // stall while the queue cannot take a frame
  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  // classify the slot: nonzero, in range, new and a voice free
  assign in_range = {1'b0, note_slot_i} < 8'(NOTE_COUNT);
  assign idx      = note_slot_i[NI_W-1:0];
  assign take     = (note_slot_i != '0) && in_range && !cur_q[idx] &&
                    (cnt_q < CW'(VOICES));

  // bitmap including this item's note
  always_comb begin
    cur_d = cur_q;
    cnt_d = cnt_q;
    if (take) begin
      cur_d = cur_q | (NOTE_COUNT'(1) << idx);
      cnt_d = cnt_q + CW'(1);
    end
  end

  // frame job handed to the back end
  assign q_push_o = accept && frame_end_i;
  assign q_diff_o = PAD_W'(cur_d ^ prev_q);
  assign q_cur_o  = PAD_W'(cur_d);

  // bitmap registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      prev_q <= '0;
      cnt_q  <= '0;
    end else if (accept) begin
      if (frame_end_i) begin
        prev_q <= cur_d;
        cur_q  <= '0;
        cnt_q  <= '0;
      end else begin
        cur_q <= cur_d;
        cnt_q <= cnt_d;
      end
    end
  end

endmodule

>>> rtl/nsc_queue.sv
module nsc_queue #(
  parameter int W = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [W-1:0]       push_data_i,
  input  logic               pop_i,
  output logic [W-1:0]       pop_data_o,
  output nsc_pkg::q_status_t status_o
);

  logic [W-1:0] slot0_q, slot1_q;
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;

  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);
  assign pop_data_o     = rd_q ? slot1_q : slot0_q;

  // two-entry frame queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot0_q <= '0;
      slot1_q <= '0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      cnt_q   <= 2'd0;
    end else begin
      if (push_i) begin
        if (wr_q) begin
          slot1_q <= push_data_i;
        end else begin
          slot0_q <= push_data_i;
        end
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> rtl/nsc_back.sv
module nsc_back #(
  parameter int PAD_W = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  nsc_pkg::q_status_t         q_status_i,
  input  logic [PAD_W-1:0]           q_diff_i,
  input  logic [PAD_W-1:0]           q_cur_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [nsc_pkg::NOTE_W-1:0] note_number_o,
  output logic [nsc_pkg::VEL_W-1:0]  velocity_o,
  output logic                       last_event_o
);

  localparam int SEG_W     = nsc_pkg::SEG_W;
  localparam int SEG_COUNT = PAD_W / SEG_W;
  localparam int SEGI_W    = $clog2(SEG_COUNT);
  localparam int BIT_W     = $clog2(SEG_W);
  localparam int NIDX_W    = SEGI_W + BIT_W;
  localparam int NW        = nsc_pkg::NOTE_W;
  localparam int EVW       = $clog2(nsc_pkg::MAX_EVENTS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e                     state_q;
  logic [PAD_W-1:0]           diff_q, cur_q, diff_after;
  logic [SEGI_W-1:0]          seg_q;
  logic [EVW-1:0]             ev_q;
  logic                       out_valid_q, last_q;
  logic [NW-1:0]              note_q;
  logic [nsc_pkg::VEL_W-1:0]  vel_q;
  logic [SEG_W-1:0]           seg_bits;
  logic [BIT_W-1:0]           hit_bit;
  logic [NIDX_W-1:0]          note_idx;
  logic                       out_free;
  logic                       is_last;
  logic                       emit;

  // current segment and its highest set bit
  assign seg_bits = diff_q[seg_q*SEG_W +: SEG_W];

  always_comb begin
    hit_bit = '0;
    for (int i = 0; i < SEG_W; i++) begin
      if (seg_bits[i]) begin
        hit_bit = BIT_W'(i);
      end
    end
  end

  assign note_idx   = {seg_q, hit_bit};
  assign diff_after = diff_q & ~(PAD_W'(1) << note_idx);
  assign is_last    = (diff_after == '0) || (ev_q == EVW'(nsc_pkg::MAX_EVENTS - 1));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign q_pop_o    = (state_q == ST_IDLE) && !q_status_i.empty;
  assign emit       = (state_q == ST_SCAN) && (diff_q != '0) && (seg_bits != '0) && out_free;

  // scan sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      diff_q      <= '0;
      cur_q       <= '0;
      seg_q       <= '0;
      ev_q        <= '0;
      out_valid_q <= 1'b0;
      note_q      <= '0;
      vel_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      // output valid: set on a new event, cleared once taken
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!q_status_i.empty) begin
            diff_q  <= q_diff_i;
            cur_q   <= q_cur_i;
            seg_q   <= SEGI_W'(SEG_COUNT - 1);
            ev_q    <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (diff_q == '0) begin
            state_q <= ST_IDLE;
          end else if (seg_bits == '0) begin
            seg_q <= seg_q - SEGI_W'(1);
          end else if (out_free) begin
            note_q      <= NW'(note_idx);
            vel_q       <= cur_q[note_idx] ? nsc_pkg::VEL_ON : nsc_pkg::VEL_OFF;
            last_q      <= is_last;
            diff_q      <= diff_after;
            ev_q        <= ev_q + EVW'(1);
            if (is_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign note_number_o = note_q;
  assign velocity_o    = vel_q;
  assign last_event_o  = last_q;

endmodule

>>> rtl/note_set_change_to_midi_events_core.sv
// flow: a slot item is taken while in_stall_o is low; on a frame end the frame job is
//   queued, the back end loads it, skips empty segments and registers each change event
// throughput: one slot item per cycle while the two-entry frame queue has room; one event
//   per cycle out unless stalled, over up to max(2, ceil(NOTE_COUNT/16)) segments
// reset: asynchronous active low, clears both note bitmaps, the queue and the output
`include "note_set_change_to_midi_events_core_macros.svh"

module note_set_change_to_midi_events_core #(
  parameter int NOTE_COUNT = nsc_pkg::NOTE_COUNT_DEF,
  parameter int VOICES     = nsc_pkg::VOICES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [nsc_pkg::NOTE_W-1:0] note_slot_i,
  input  logic                       frame_end_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [nsc_pkg::NOTE_W-1:0] note_number_o,
  output logic [nsc_pkg::VEL_W-1:0]  velocity_o,
  output logic                       last_event_o
);

  localparam int SEG_RAW   = (NOTE_COUNT + nsc_pkg::SEG_W - 1) / nsc_pkg::SEG_W;
  localparam int SEG_COUNT = (SEG_RAW < 2) ? 2 : SEG_RAW;
  localparam int PAD_W     = SEG_COUNT * nsc_pkg::SEG_W;

  nsc_pkg::q_status_t q_status;
  logic               q_push, q_pop;
  logic [PAD_W-1:0]   push_diff, push_cur, pop_diff, pop_cur;
  logic               vel_ok;

  // slot intake and bitmap keeping
  nsc_front #(
    .NOTE_COUNT (NOTE_COUNT),
    .VOICES     (VOICES),
    .PAD_W      (PAD_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .note_slot_i (note_slot_i),
    .frame_end_i (frame_end_i),
    .q_status_i  (q_status),
    .q_push_o    (q_push),
    .q_diff_o    (push_diff),
    .q_cur_o     (push_cur)
  );

  // frame jobs between front and back
  nsc_queue #(
    .W (2 * PAD_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i ({push_diff, push_cur}),
    .pop_i       (q_pop),
    .pop_data_o  ({pop_diff, pop_cur}),
    .status_o    (q_status)
  );

  // change scan and event output
  nsc_back #(
    .PAD_W (PAD_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_status_i    (q_status),
    .q_diff_i      (pop_diff),
    .q_cur_i       (pop_cur),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .note_number_o (note_number_o),
    .velocity_o    (velocity_o),
    .last_event_o  (last_event_o)
  );

  // velocity is one of the two codes
  assign vel_ok = (velocity_o == nsc_pkg::VEL_ON) || (velocity_o == nsc_pkg::VEL_OFF);

  // checks
  `NSC_ASSERT(a_no_push_full, q_push |-> !q_status.full, "frame pushed into a full queue")
  `NSC_ASSERT(a_no_pop_empty, q_pop |-> !q_status.empty, "frame popped from an empty queue")
  `NSC_ASSERT(a_vel_code, out_valid_o |-> vel_ok, "bad velocity code")

endmodule

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NOTE_COUNT   = nsc_pkg::NOTE_COUNT_DEF;
  localparam int VOICES       = nsc_pkg::VOICES_DEF;
  localparam int NOTE_W       = nsc_pkg::NOTE_W;
  localparam int VEL_W        = nsc_pkg::VEL_W;
  localparam int DIRECTED_N   = 25;
  localparam int RANDOM_ITEMS = 345;
  localparam int PAUSE_ITEM   = DIRECTED_N + 200;
  localparam int HOLD_AFTER   = 40;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 64;
  localparam int IDLE_LIMIT   = 3000;

  // one slot item, with an optional typed-in expected event
  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic              fe;
    logic              typed;
    logic [NOTE_W-1:0] t_note;
    logic [VEL_W-1:0]  t_vel;
    logic              t_last;
  } slot_row_t;

  // one note on/off event
  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic              last;
  } midi_event_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [NOTE_W-1:0] note_slot_i;
  logic              frame_end_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [NOTE_W-1:0] note_number_o;
  logic [VEL_W-1:0]  velocity_o;
  logic              last_event_o;

  note_set_change_to_midi_events_core #(
    .NOTE_COUNT(NOTE_COUNT),
    .VOICES    (VOICES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .note_slot_i  (note_slot_i),
    .frame_end_i  (frame_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .note_number_o(note_number_o),
    .velocity_o   (velocity_o),
    .last_event_o (last_event_o)
  );

  // directed slot items: reset state, extremes, voice limit, full change set
  slot_row_t directed_rows [DIRECTED_N] = '{
    '{7'd60,  1'b1, 1'b1, 7'd60,  nsc_pkg::VEL_ON,  1'b1},
    '{7'd0,   1'b1, 1'b1, 7'd60,  nsc_pkg::VEL_OFF, 1'b1},
    '{7'd127, 1'b1, 1'b1, 7'd127, nsc_pkg::VEL_ON,  1'b1},
    '{7'd1,   1'b1, 1'b0, 7'd0,   nsc_pkg::VEL_OFF, 1'b0},
    '{7'd0,   1'b1, 1'b1, 7'd1,   nsc_pkg::VEL_OFF, 1'b1},
    '{7'd0,   1'b1, 1'b0, 7'd0,   nsc_pkg::VEL_OFF, 1'b0},
    '{7'd10,  1'b0, 1'b0, 7'd0,   nsc_pkg::VEL_OFF, 1'b0},
    '{7'd10,  1'b0, 1'b0, 7'd0,   nsc_pkg::VEL_OFF, 1'b0},
    '{7'd11,  1'b0, 1'b0, 7'd0,   nsc_pkg::VEL_OFF, 1'b0},
    '{7'd12,  1'b0, 1'b0, 7'd0,   nsc_pkg::VEL_OFF, 1'b0},
    '{7'd13,  1'b0, 1'b0, 7'd0,   nsc_pkg::VEL_OFF, 1'b0},
    '{7'd14,  1'b0, 1'b0, 7'd0,   nsc_pkg::VEL_OFF, 1'b0},
    '{7'd15,  1'b0, 1'b0, 7'd0,   nsc_pkg::VEL_OFF, 1'b0},
    '{7'd16,  1'b0, 1'b0, 7'd0,   nsc_pkg::VEL_OFF, 1'b0},
    '{7'd17,  1'b0, 1'b0, 7'd0,   nsc_pkg::VEL_OFF, 1'b0},
    '{7'd18,  1'b1, 1'b0, 7'd0,   nsc_pkg::VEL_OFF, 1'b0},
    '{7'd100, 1'b0, 1'b0, 7'd0,   nsc_pkg::VEL_OFF, 1'b0},
    '{7'd101, 1'b0, 1'b0, 7'd0,   nsc_pkg::VEL_OFF, 1'b0},
    '{7'd102, 1'b0, 1'b0, 7'd0,   nsc_pkg::VEL_OFF, 1'b0},
    '{7'd103, 1'b0, 1'b0, 7'd0,   nsc_pkg::VEL_OFF, 1'b0},
    '{7'd104, 1'b0, 1'b0, 7'd0,   nsc_pkg::VEL_OFF, 1'b0},
    '{7'd105, 1'b0, 1'b0, 7'd0,   nsc_pkg::VEL_OFF, 1'b0},
    '{7'd106, 1'b0, 1'b0, 7'd0,   nsc_pkg::VEL_OFF, 1'b0},
    '{7'd107, 1'b1, 1'b0, 7'd0,   nsc_pkg::VEL_OFF, 1'b0},
    '{7'd0,   1'b1, 1'b0, 7'd0,   nsc_pkg::VEL_OFF, 1'b0}
  };

  slot_row_t         slot_items [$];
  midi_event_t       pending_events [$];
  midi_event_t       frame_events [$];
  logic [NOTE_W-1:0] note_pool [12];

  // note set state of the predictor
  bit [NOTE_COUNT-1:0] held_notes;
  bit [NOTE_COUNT-1:0] last_frame_notes;
  int unsigned         held_count;

  int  fail_cnt;
  int  events_taken;
  bit  long_hold_on;
  bit  long_hold_done;

  // take one slot into the note set, and on a frame end list the changes
  function automatic void advance_note_sets(input logic [NOTE_W-1:0] note, input logic fe);
    int          k;
    midi_event_t ev;
    frame_events.delete();
    if (note != 0 && int'(note) < NOTE_COUNT && !held_notes[note] && held_count < VOICES) begin
      held_notes[note] = 1'b1;
      held_count++;
    end
    if (fe) begin
      for (k = NOTE_COUNT - 1; k >= 0; k--) begin
        if (held_notes[k] != last_frame_notes[k] &&
            frame_events.size() < nsc_pkg::MAX_EVENTS) begin
          ev.note = NOTE_W'(k);
          ev.vel  = held_notes[k] ? nsc_pkg::VEL_ON : nsc_pkg::VEL_OFF;
          ev.last = 1'b0;
          frame_events.push_back(ev);
        end
      end
      if (frame_events.size() > 0) begin
        ev = frame_events.pop_back();
        ev.last = 1'b1;
        frame_events.push_back(ev);
      end
      last_frame_notes = held_notes;
      held_notes = '0;
      held_count = 0;
    end
  endfunction

  // idle cycles before an item, with bursts of no idling
  function automatic int pick_wait(input int idx);
    if ((idx / 40) % 3 == 2) return 0;
    return $urandom_range(0, 15);
  endfunction

  // build random frames: pool notes, wide notes, silent, overfull and noise frames
  function automatic void build_random_frames();
    int        kind;
    int        len;
    int        s;
    slot_row_t row;
    note_pool[0] = 7'd127;
    note_pool[1] = 7'd1;
    for (s = 2; s < 12; s++) note_pool[s] = NOTE_W'($urandom_range(1, 127));
    while (slot_items.size() < DIRECTED_N + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      len  = (kind == 8) ? 12 : $urandom_range(1, 10);
      for (s = 0; s < len; s++) begin
        row = '0;
        row.fe = (s == len - 1);
        case (kind)
          0, 8: row.note = NOTE_W'($urandom_range(0, 127));
          7: begin
            row.note = ($urandom_range(0, 3) == 0) ? note_pool[$urandom_range(0, 11)] : '0;
          end
          9: begin
            row.note = NOTE_W'($urandom_range(0, 127));
            row.fe   = 1'($urandom_range(0, 1));
          end
          default: begin
            row.note = ($urandom_range(0, 7) == 0) ? '0 : note_pool[$urandom_range(0, 11)];
          end
        endcase
        slot_items.push_back(row);
      end
    end
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stalls, one long hold-off, compare against the oldest expectation
  initial begin
    int          hold;
    midi_event_t ev;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = pick_wait(events_taken);
      if (!long_hold_done && events_taken >= HOLD_AFTER) begin
        hold = LONG_HOLD;
        long_hold_done = 1'b1;
        long_hold_on = 1'b1;
      end
      out_stall_i <= (hold != 0);
      if (hold != 0) begin
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
        long_hold_on = 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_stall_i === 1'b0));
      events_taken++;
      if (pending_events.size() == 0) begin
        $error("event with none expected: note_number %0d velocity %0d", note_number_o,
               velocity_o);
        fail_cnt++;
      end else begin
        ev = pending_events.pop_front();
        if (note_number_o !== ev.note) begin
          $error("note_number: expected %0d, got %0d", ev.note, note_number_o);
          fail_cnt++;
        end
        if (velocity_o !== ev.vel) begin
          $error("velocity: expected %0d, got %0d", ev.vel, velocity_o);
          fail_cnt++;
        end
        if (last_event_o !== ev.last) begin
          $error("last_event: expected %0d, got %0d", ev.last, last_event_o);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
          (out_valid_o === 1'b1 && out_stall_i === 1'b0))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // reset, slot items in, drain, verdict
  initial begin
    int          i;
    int          gap;
    midi_event_t ev;
    slot_row_t   row;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    note_slot_i <= '0;
    frame_end_i <= 1'b0;
    held_notes = '0;
    last_frame_notes = '0;
    held_count = 0;
    fail_cnt = 0;
    events_taken = 0;
    long_hold_on = 1'b0;
    long_hold_done = 1'b0;
    for (i = 0; i < DIRECTED_N; i++) slot_items.push_back(directed_rows[i]);
    build_random_frames();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < slot_items.size(); i++) begin
      row = slot_items[i];
      gap = long_hold_on ? 0 : pick_wait(i);
      if (i == PAUSE_ITEM && gap == 0) gap = 1;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      // sender pause until every expected event is out
      if (i == PAUSE_ITEM) begin
        while (pending_events.size() != 0) @(posedge clk_i);
      end
      in_valid_i  <= 1'b1;
      note_slot_i <= row.note;
      frame_end_i <= row.fe;
      do @(posedge clk_i); while (!(in_valid_i === 1'b1 && in_stall_o === 1'b0));
      advance_note_sets(row.note, row.fe);
      if (row.typed) begin
        ev.note = row.t_note;
        ev.vel  = row.t_vel;
        ev.last = row.t_last;
        pending_events.push_back(ev);
      end else begin
        foreach (frame_events[j]) pending_events.push_back(frame_events[j]);
      end
    end
    in_valid_i <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && pending_events.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> note_set_change_to_midi_events_core.f
+incdir+rtl
rtl/nsc_pkg.sv
rtl/nsc_front.sv
rtl/nsc_queue.sv
rtl/nsc_back.sv
rtl/note_set_change_to_midi_events_core.sv
tb/testbench.sv
